@@ hdl/curvature_scaled_momentum_update_defines.svh @@
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef CURVATURE_SCALED_MOMENTUM_UPDATE_DEFINES_SVH
`define CURVATURE_SCALED_MOMENTUM_UPDATE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define CSMU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("csmu check failed");

// condition holds in the cycle after the trigger
`define CSMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("csmu check failed");

`endif

@@ hdl/csmu_pkg.sv @@
// shared constants, types and saturation helper for the momentum update block
// no dependencies
package csmu_pkg;

  localparam int unsigned ELEMENTS    = 4096;
  localparam int unsigned IDX_W       = $clog2(ELEMENTS);
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned FRAC_BITS   = 24;
  localparam int unsigned MOM_W       = 16;
  localparam int unsigned ITER_W      = 20;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned DVSR_W      = VAL_W + 1;
  localparam int unsigned DIVD_W      = VAL_W + FRAC_BITS;
  localparam int unsigned QUOT_W      = VAL_W;
  localparam int unsigned DIV_STAGES  = QUOT_W;
  localparam int unsigned HZ_STAGES   = DIV_STAGES + 6;
  localparam int unsigned PIPE_STAGES = DIV_STAGES + 7;
  localparam int unsigned MAX_PENDING = PIPE_STAGES + 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MOM_EARLY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MOM_LATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURV_MOM_EARLY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURV_MOM_LATE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_ITER    = 3'd6;

  localparam logic [VAL_W-1:0]  DAMPING_RESET = 32'd167772;
  localparam logic [ITER_W-1:0] SWITCH_RESET  = 20'd30;

  typedef logic signed [VAL_W-1:0] value_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    value_t           weight;
    value_t           grad;
    value_t           vel_old;
    logic [MOM_W-1:0] mv;
    logic             flag;
  } side_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef struct packed {
    value_t value;
    logic   flag;
  } sat_t;

  typedef struct packed {
    value_t weight;
    logic   flag;
  } result_t;

  function automatic sat_t clamp_val(input logic signed [63:0] v);
    sat_t                r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      r.value = hi[VAL_W-1:0];
      r.flag  = 1'b1;
    end else if (v < lo) begin
      r.value = lo[VAL_W-1:0];
      r.flag  = 1'b1;
    end else begin
      r.value = v[VAL_W-1:0];
      r.flag  = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ hdl/csmu_if.sv @@
// valid/ready channel interfaces for items and results
// depends on csmu_pkg
interface csmu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [csmu_pkg::IDX_W-1:0]     element_index;
  logic signed [csmu_pkg::VAL_W-1:0]     weight_in;
  logic signed [csmu_pkg::VAL_W-1:0]     gradient;
  logic signed [csmu_pkg::VAL_W-1:0]     curvature;
  logic        [csmu_pkg::ITER_W-1:0]    iteration;

  modport source (output valid, element_index, weight_in, gradient, curvature, iteration,
                  input ready);
  modport sink (input valid, element_index, weight_in, gradient, curvature, iteration,
                output ready);
endinterface

interface csmu_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [csmu_pkg::VAL_W-1:0] weight_out;
  logic                              saturated;

  modport source (output valid, weight_out, saturated, input ready);
  modport sink (input valid, weight_out, saturated, output ready);
endinterface

@@ hdl/csmu_blend.sv @@
// momentum blend: registered products, then round, shift and clamp
// depends on csmu_pkg
module csmu_blend (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [csmu_pkg::MOM_W-1:0] mom_i,
  input  csmu_pkg::value_t        old_i,
  input  csmu_pkg::value_t        fresh_i,
  output csmu_pkg::sat_t          result_o
);
  localparam int unsigned PROD_W = csmu_pkg::VAL_W + csmu_pkg::MOM_W + 2;

  logic [csmu_pkg::MOM_W:0]  comp;
  logic signed [PROD_W-1:0]  prod_old_q;
  logic signed [PROD_W-1:0]  prod_new_q;
  logic signed [PROD_W:0]    acc;

  assign comp = (csmu_pkg::MOM_W + 1)'(1 << csmu_pkg::MOM_W) - {1'b0, mom_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_old_q <= $signed({2'b00, mom_i}) * old_i;
      prod_new_q <= $signed({1'b0, comp}) * fresh_i;
    end
  end

  // round to nearest, floor shift
  always_comb begin
    acc      = (PROD_W + 1)'(prod_old_q) + (PROD_W + 1)'(prod_new_q)
             + $signed((PROD_W + 1)'(1 << (csmu_pkg::MOM_W - 1)));
    result_o = csmu_pkg::clamp_val(64'(acc >>> csmu_pkg::MOM_W));
  end
endmodule

@@ hdl/csmu_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on csmu_pkg
module csmu_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [csmu_pkg::DIVD_W-1:0]   dividend_i,
  input  logic [csmu_pkg::DVSR_W-1:0]   divisor_i,
  input  csmu_pkg::side_t               side_i,
  output logic                          out_valid_o,
  output logic [csmu_pkg::QUOT_W-1:0]   quot_o,
  output csmu_pkg::side_t               side_o,
  output csmu_pkg::tag_t                tags_o [csmu_pkg::DIV_STAGES]
);
  localparam int unsigned NS    = csmu_pkg::DIV_STAGES;
  localparam int unsigned CMP_W = csmu_pkg::DVSR_W + csmu_pkg::QUOT_W - 1;

  logic                          valid_q [NS];
  logic                          valid_d [NS];
  logic [csmu_pkg::DIVD_W-1:0]   rem_q   [NS];
  logic [csmu_pkg::DIVD_W-1:0]   rem_d   [NS];
  logic [csmu_pkg::DVSR_W-1:0]   dvsr_q  [NS];
  logic [csmu_pkg::DVSR_W-1:0]   dvsr_d  [NS];
  logic [csmu_pkg::QUOT_W-1:0]   quot_q  [NS];
  logic [csmu_pkg::QUOT_W-1:0]   quot_d  [NS];
  csmu_pkg::side_t               side_q  [NS];
  csmu_pkg::side_t               side_d  [NS];

  // top stage decides bit 31, which doubles as the overflow test
  always_comb begin
    logic [csmu_pkg::DIVD_W-1:0] rem_p;
    logic [csmu_pkg::DVSR_W-1:0] dv_p;
    logic [csmu_pkg::QUOT_W-1:0] q_p;
    csmu_pkg::side_t             sd_p;
    logic                        v_p;
    logic [CMP_W-1:0]            shifted;
    logic                        ge;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rem_p = dividend_i;
        dv_p  = divisor_i;
        q_p   = '0;
        sd_p  = side_i;
        v_p   = in_valid_i;
      end else begin
        rem_p = rem_q[s-1];
        dv_p  = dvsr_q[s-1];
        q_p   = quot_q[s-1];
        sd_p  = side_q[s-1];
        v_p   = valid_q[s-1];
      end
      shifted    = CMP_W'(dv_p) << (NS - 1 - s);
      ge         = (CMP_W'(rem_p) >= shifted);
      rem_d[s]   = ge ? csmu_pkg::DIVD_W'(CMP_W'(rem_p) - shifted) : rem_p;
      quot_d[s]  = q_p;
      quot_d[s][NS - 1 - s] = ge;
      dvsr_d[s]  = dv_p;
      side_d[s]  = sd_p;
      valid_d[s] = v_p;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < NS; s++) valid_q[s] <= valid_d[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        rem_q[s]  <= rem_d[s];
        dvsr_q[s] <= dvsr_d[s];
        quot_q[s] <= quot_d[s];
        side_q[s] <= side_d[s];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < NS; s++) begin
      tags_o[s].valid = valid_q[s];
      tags_o[s].idx   = side_q[s].idx;
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign quot_o      = quot_q[NS-1];
  assign side_o      = side_q[NS-1];
endmodule

@@ hdl/curvature_scaled_momentum_update.sv @@
// throughput: one transaction per cycle, set by the 32-stage divider pipeline,
// unless the output buffer is full or the input waits on an element hazard
// an item whose element index is still in flight waits until the earlier
// velocity write-back is done, set by the state memory ports
// reset: async active low; afterwards a pass over all 4096 elements
// zeroes both state memories, during which no input transaction is accepted
module curvature_scaled_momentum_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  csmu_in_if.sink                           in_if,
  csmu_out_if.source                        out_if,
  input  logic                              cfg_we_i,
  input  logic [csmu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [csmu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  localparam int unsigned VW = csmu_pkg::VAL_W;

  // configuration registers
  logic [VW-1:0]                 lr_q;
  logic [VW-1:0]                 damping_q;
  logic [csmu_pkg::MOM_W-1:0]    vm_early_q;
  logic [csmu_pkg::MOM_W-1:0]    vm_late_q;
  logic [csmu_pkg::MOM_W-1:0]    cm_early_q;
  logic [csmu_pkg::MOM_W-1:0]    cm_late_q;
  logic [csmu_pkg::ITER_W-1:0]   switch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q       <= '0;
      damping_q  <= csmu_pkg::DAMPING_RESET;
      vm_early_q <= '0;
      vm_late_q  <= '0;
      cm_early_q <= '0;
      cm_late_q  <= '0;
      switch_q   <= csmu_pkg::SWITCH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csmu_pkg::REG_LEARNING_RATE:  lr_q       <= cfg_data_i[VW-1:0];
        csmu_pkg::REG_DAMPING:        damping_q  <= cfg_data_i[VW-1:0];
        csmu_pkg::REG_VEL_MOM_EARLY:  vm_early_q <= cfg_data_i[csmu_pkg::MOM_W-1:0];
        csmu_pkg::REG_VEL_MOM_LATE:   vm_late_q  <= cfg_data_i[csmu_pkg::MOM_W-1:0];
        csmu_pkg::REG_CURV_MOM_EARLY: cm_early_q <= cfg_data_i[csmu_pkg::MOM_W-1:0];
        csmu_pkg::REG_CURV_MOM_LATE:  cm_late_q  <= cfg_data_i[csmu_pkg::MOM_W-1:0];
        csmu_pkg::REG_SWITCH_ITER:    switch_q   <= cfg_data_i[csmu_pkg::ITER_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // clearing pass over both memories after reset
  logic                        clr_busy_q;
  logic [csmu_pkg::IDX_W-1:0]  clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == csmu_pkg::IDX_W'(csmu_pkg::ELEMENTS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // pipeline advance: frozen only while the output buffer is full
  logic [1:0] cnt_q;
  logic       adv;
  logic       hazard;
  logic       in_acc;

  assign adv         = (cnt_q != 2'd2);
  assign in_if.ready = adv && !hazard && !clr_busy_q;
  assign in_acc      = in_if.valid && in_if.ready;

  // stage valids
  logic a_valid_q, b_valid_q, c_valid_q, m_valid_q, s_valid_q, vb_valid_q, vc_valid_q;
  logic div_valid;

  // stage payloads
  csmu_pkg::side_t              a_side_q, b_side_q, c_side_q, m_side_q, s_side_q;
  csmu_pkg::side_t              vb_side_q, vc_side_q, div_side;
  csmu_pkg::side_t              a_side_d, b_side_d, c_div_side;
  csmu_pkg::side_t              c_side_d, m_side_d, s_side_d, vc_side_d;
  csmu_pkg::value_t             a_curv_q;
  logic [csmu_pkg::MOM_W-1:0]   a_mc_q;
  csmu_pkg::value_t             c_avg_q;
  logic signed [2*VW-1:0]       m_prod_q;
  csmu_pkg::value_t             s_step_q;
  csmu_pkg::value_t             vc_vel_q;

  // state memories, read at accept, data registered into stage a
  csmu_pkg::value_t             curv_mem [csmu_pkg::ELEMENTS];
  csmu_pkg::value_t             vel_mem  [csmu_pkg::ELEMENTS];
  csmu_pkg::value_t             curv_rd_q, vel_rd_q;
  logic                         curv_we, vel_we;
  logic [csmu_pkg::IDX_W-1:0]   curv_wa, vel_wa;
  csmu_pkg::value_t             curv_wd, vel_wd;

  csmu_pkg::sat_t               avg, vel, step, res;

  always_ff @(posedge clk_i) begin
    if (curv_we) begin
      curv_mem[curv_wa] <= curv_wd;
    end
    if (adv) begin
      curv_rd_q <= curv_mem[in_if.element_index];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vel_we) begin
      vel_mem[vel_wa] <= vel_wd;
    end
    if (adv) begin
      vel_rd_q <= vel_mem[in_if.element_index];
    end
  end

  // write ports: clearing pass, curvature write-back at b, velocity at vb
  always_comb begin
    curv_we = clr_busy_q || (b_valid_q && adv);
    curv_wa = clr_busy_q ? clr_cnt_q : b_side_q.idx;
    curv_wd = clr_busy_q ? '0 : avg.value;
    vel_we  = clr_busy_q || (vb_valid_q && adv);
    vel_wa  = clr_busy_q ? clr_cnt_q : vb_side_q.idx;
    vel_wd  = clr_busy_q ? '0 : vel.value;
  end

  // momentum choice at accept
  logic late;
  assign late = (in_if.iteration > switch_q);

  always_comb begin
    a_side_d.idx     = in_if.element_index;
    a_side_d.weight  = in_if.weight_in;
    a_side_d.grad    = in_if.gradient;
    a_side_d.vel_old = '0;
    a_side_d.mv      = late ? vm_late_q : vm_early_q;
    a_side_d.flag    = 1'b0;
    b_side_d         = a_side_q;
    b_side_d.vel_old = vel_rd_q;
  end

  // curvature average blend, products at b
  csmu_blend u_blend_curv (
    .clk_i   (clk_i),
    .en_i    (adv),
    .mom_i   (a_mc_q),
    .old_i   (curv_rd_q),
    .fresh_i (a_curv_q),
    .result_o(avg)
  );

  // divisor from the stored average plus damping, floored at one lsb
  logic signed [VW+1:0]          div_sum;
  logic [csmu_pkg::DVSR_W-1:0]   dvsr;
  logic                          dvsr_low;

  always_comb begin
    div_sum  = (VW + 2)'(c_avg_q) + $signed({2'b00, damping_q});
    dvsr_low = (div_sum < $signed((VW + 2)'(1)));
    dvsr     = dvsr_low ? csmu_pkg::DVSR_W'(1) : div_sum[csmu_pkg::DVSR_W-1:0];
    c_div_side      = c_side_q;
    c_div_side.flag = c_side_q.flag | dvsr_low;
  end

  logic [csmu_pkg::QUOT_W-1:0]   div_quot;
  csmu_pkg::tag_t                div_tags [csmu_pkg::DIV_STAGES];

  csmu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .in_valid_i (c_valid_q),
    .dividend_i ({lr_q, csmu_pkg::FRAC_BITS'(0)}),
    .divisor_i  (dvsr),
    .side_i     (c_div_side),
    .out_valid_o(div_valid),
    .quot_o     (div_quot),
    .side_o     (div_side),
    .tags_o     (div_tags)
  );

  // rate clamps to the signed maximum when the top quotient bit is set
  logic          rate_sat;
  logic [VW-1:0] rate;
  assign rate_sat = div_quot[csmu_pkg::QUOT_W-1];
  assign rate     = rate_sat ? {1'b0, {(VW - 1){1'b1}}} : {1'b0, div_quot[VW-2:0]};

  // step = round(gradient * rate) back to q8.24
  always_comb begin
    step = csmu_pkg::clamp_val(64'((m_prod_q + (64'sd1 <<< (csmu_pkg::FRAC_BITS - 1)))
                               >>> csmu_pkg::FRAC_BITS));
  end

  // velocity blend, products at vb
  csmu_blend u_blend_vel (
    .clk_i   (clk_i),
    .en_i    (adv),
    .mom_i   (s_side_q.mv),
    .old_i   (s_side_q.vel_old),
    .fresh_i (s_step_q),
    .result_o(vel)
  );

  // final weight
  always_comb begin
    res = csmu_pkg::clamp_val(64'(vc_side_q.weight) - 64'(vc_vel_q));
  end

  // sideband for the next stages, saturation flags gathered on the way
  always_comb begin
    c_side_d       = b_side_q;
    c_side_d.flag  = b_side_q.flag | avg.flag;
    m_side_d       = div_side;
    m_side_d.flag  = div_side.flag | rate_sat;
    s_side_d       = m_side_q;
    s_side_d.flag  = m_side_q.flag | step.flag;
    vc_side_d      = vb_side_q;
    vc_side_d.flag = vb_side_q.flag | vel.flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      b_valid_q  <= 1'b0;
      c_valid_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      s_valid_q  <= 1'b0;
      vb_valid_q <= 1'b0;
      vc_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q  <= in_acc;
      b_valid_q  <= a_valid_q;
      c_valid_q  <= b_valid_q;
      m_valid_q  <= div_valid;
      s_valid_q  <= m_valid_q;
      vb_valid_q <= s_valid_q;
      vc_valid_q <= vb_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_side_q  <= a_side_d;
      a_curv_q  <= in_if.curvature;
      a_mc_q    <= late ? cm_late_q : cm_early_q;
      b_side_q  <= b_side_d;
      c_side_q  <= c_side_d;
      c_avg_q   <= avg.value;
      m_prod_q  <= div_side.grad * $signed({1'b0, rate});
      m_side_q  <= m_side_d;
      s_step_q  <= step.value;
      s_side_q  <= s_side_d;
      vb_side_q <= s_side_q;
      vc_vel_q  <= vel.value;
      vc_side_q <= vc_side_d;
    end
  end

  // interlock: same element anywhere before its velocity write-back
  csmu_pkg::tag_t hz_tags [csmu_pkg::HZ_STAGES];

  always_comb begin
    hz_tags[0] = '{valid: a_valid_q,  idx: a_side_q.idx};
    hz_tags[1] = '{valid: b_valid_q,  idx: b_side_q.idx};
    hz_tags[2] = '{valid: c_valid_q,  idx: c_side_q.idx};
    hz_tags[3] = '{valid: m_valid_q,  idx: m_side_q.idx};
    hz_tags[4] = '{valid: s_valid_q,  idx: s_side_q.idx};
    hz_tags[5] = '{valid: vb_valid_q, idx: vb_side_q.idx};
    for (int i = 0; i < csmu_pkg::DIV_STAGES; i++) begin
      hz_tags[i + 6] = div_tags[i];
    end
    hazard = 1'b0;
    for (int i = 0; i < csmu_pkg::HZ_STAGES; i++) begin
      hazard = hazard | (hz_tags[i].valid && (hz_tags[i].idx == in_if.element_index));
    end
  end

  // two-entry output buffer parts the pipeline from the result transaction
  csmu_pkg::result_t buf_q [2];
  csmu_pkg::result_t push_data;
  logic              push, pop;

  assign push_data.weight = res.value;
  assign push_data.flag   = vc_side_q.flag | res.flag;
  assign push = vc_valid_q && adv;
  assign pop  = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (push && pop) begin
      if (cnt_q == 2'd1) begin
        buf_q[0] <= push_data;
      end else begin
        buf_q[0] <= buf_q[1];
        buf_q[1] <= push_data;
      end
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end else if (push) begin
      if (cnt_q == 2'd0) begin
        buf_q[0] <= push_data;
      end else begin
        buf_q[1] <= push_data;
      end
    end
  end

  assign out_if.valid      = (cnt_q != 2'd0);
  assign out_if.weight_out = buf_q[0].weight;
  assign out_if.saturated  = buf_q[0].flag;
endmodule

@@ hdl/csmu_checker.sv @@
// port-level checker for the momentum update block, bound to the top level
// depends on csmu_pkg and curvature_scaled_momentum_update_defines.svh
`include "curvature_scaled_momentum_update_defines.svh"

module csmu_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input csmu_pkg::value_t weight_out_i,
  input logic             saturated_i
);
  localparam int unsigned PEND_W = $clog2(csmu_pkg::MAX_PENDING + 1) + 1;

  logic [PEND_W-1:0] pend_q;
  logic              acc, del;

  assign acc = in_valid_i && in_ready_i;
  assign del = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PEND_W'(acc) - PEND_W'(del);
    end
  end

  `CSMU_ASSERT_SAME(a_no_orphan_result, clk_i, rst_ni, del, pend_q != '0)
  `CSMU_ASSERT_SAME(a_pending_bounded, clk_i, rst_ni, 1'b1, pend_q <= PEND_W'(csmu_pkg::MAX_PENDING))
  `CSMU_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `CSMU_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(weight_out_i) && $stable(saturated_i))
endmodule

bind curvature_scaled_momentum_update csmu_checker u_csmu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .weight_out_i(out_if.weight_out),
  .saturated_i (out_if.saturated)
);
